### rtl/core/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_KEYS = 4;
    localparam int unsigned KEY_IDX_W = 2;

    // Round constant
    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // Key register indexes on the configuration channel
    localparam logic [KEY_IDX_W-1:0] KEY_IDX0 = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX1 = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX2 = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX3 = 2'd3;

    // Operation codes carried on tuser
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

    // One block in flight between pipeline stages
    typedef struct packed {
        logic              valid;
        logic              func;
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
    } blk_t;

    // Mixing term of one half-round
    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] h,
        input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W-1:0] t1;
        logic [WORD_W-1:0] t2;
        logic [WORD_W-1:0] t3;
        t1 = (h << 4) + a;
        t2 = h + s;
        t3 = (h >> 5) + b;
        return t1 ^ t2 ^ t3;
    endfunction

endpackage

### rtl/core/tea_block_cipher.sv
`timescale 1ns / 1ps

// TEA block cipher, fully pipelined: one 64-bit block per cycle in, one out, when not stalled.
// Each of the 2*ROUNDS stages holds one half-round, and every block gives
// exactly one result. The whole pipeline holds while a finished block
// waits on m_tready; otherwise a transfer can happen every cycle. tuser
// selects encryption (0) or decryption (1) per block. The four key words
// are written through the cfg channel, reset to zero, and must be changed
// only while no block is in the pipeline.
module tea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] left_in, [63:32] right_in
    input  logic [0:0]  s_tuser,   // [0] func
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] left_out, [63:32] right_out
    // Key configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NUM_STAGES = 2 * ROUNDS;

    tea_pkg::key_t             key_reg;
    tea_pkg::blk_t             blk_in;
    tea_pkg::blk_t [NUM_STAGES-1:0] stage_out;
    logic [NUM_STAGES-1:0]     stage_vld;
    logic                      adv;

    // Key registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tea_pkg::KEY_IDX0: key_reg[0] <= cfg_data;
                tea_pkg::KEY_IDX1: key_reg[1] <= cfg_data;
                tea_pkg::KEY_IDX2: key_reg[2] <= cfg_data;
                tea_pkg::KEY_IDX3: key_reg[3] <= cfg_data;
                default: key_reg <= key_reg;
            endcase
        end
    end

    // Pipeline moves when the output stage is empty or being drained
    assign adv      = !stage_out[NUM_STAGES-1].valid || m_tready;
    assign s_tready = adv;

    assign blk_in.valid = s_tvalid;
    assign blk_in.func  = s_tuser[0];
    assign blk_in.left  = s_tdata[31:0];
    assign blk_in.right = s_tdata[63:32];

    // Half-round stages with their round sums fixed at elaboration
    genvar s;
    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            localparam int RND = s / 2;
            localparam logic [63:0] ENC_P = 64'(tea_pkg::TEA_DELTA) * 64'(RND + 1);
            localparam logic [63:0] DEC_P = 64'(tea_pkg::TEA_DELTA) * 64'(ROUNDS - RND);

            tea_pkg::blk_t stage_in;

            if (s == 0)
            begin : g_first
                assign stage_in = blk_in;
            end
            else
            begin : g_rest
                assign stage_in = stage_out[s-1];
            end

            tea_half_round #(
                .ENC_SUM (ENC_P[31:0]),
                .DEC_SUM (DEC_P[31:0]),
                .SECOND  ((s % 2) == 1)
            ) u_half (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .key     (key_reg),
                .blk_in  (stage_in),
                .blk_out (stage_out[s])
            );

            assign stage_vld[s] = stage_out[s].valid;
        end
    endgenerate

    // Output
    assign m_tvalid = stage_out[NUM_STAGES-1].valid;
    assign m_tdata  = {stage_out[NUM_STAGES-1].right, stage_out[NUM_STAGES-1].left};

    // A taken block shows up in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> stage_vld[0])
        else $error("accepted block missing from first stage");

    // A stall freezes every valid bit
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(stage_vld))
        else $error("pipeline moved during stall");

    // A write to key word 0 lands in its register
    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == tea_pkg::KEY_IDX0
        |=> key_reg[0] == $past(cfg_data))
        else $error("key word 0 write lost");

endmodule

### rtl/core/tea_half_round.sv
`timescale 1ns / 1ps

// One registered half-round. Encryption adds the mix term, decryption
// subtracts it. The half that feeds the mix and the key pair swap between
// the first and second half of a round and between the two directions.
module tea_half_round #(
    parameter logic [31:0] ENC_SUM = 32'h0,
    parameter logic [31:0] DEC_SUM = 32'h0,
    parameter bit          SECOND  = 1'b0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  tea_pkg::key_t  key,
    input  tea_pkg::blk_t  blk_in,
    output tea_pkg::blk_t  blk_out
);

    logic                         valid_reg;
    logic                         func_reg;
    logic [tea_pkg::WORD_W-1:0]   left_reg;
    logic [tea_pkg::WORD_W-1:0]   right_reg;

    logic                         src_left;
    logic [tea_pkg::WORD_W-1:0]   src;
    logic [tea_pkg::WORD_W-1:0]   dst;
    logic [tea_pkg::WORD_W-1:0]   sum;
    logic [tea_pkg::WORD_W-1:0]   ka;
    logic [tea_pkg::WORD_W-1:0]   kb;
    logic [tea_pkg::WORD_W-1:0]   term;
    logic [tea_pkg::WORD_W-1:0]   dst_next;
    logic [tea_pkg::WORD_W-1:0]   left_next;
    logic [tea_pkg::WORD_W-1:0]   right_next;

    // Operand selection
    always_comb
    begin
        src_left = blk_in.func ^ SECOND;
        src      = src_left ? blk_in.left  : blk_in.right;
        dst      = src_left ? blk_in.right : blk_in.left;
        ka       = src_left ? key[2] : key[0];
        kb       = src_left ? key[3] : key[1];
        sum      = (blk_in.func == tea_pkg::FUNC_DEC) ? DEC_SUM : ENC_SUM;
        term     = tea_pkg::mix(src, sum, ka, kb);
        dst_next = (blk_in.func == tea_pkg::FUNC_DEC) ? (dst - term) : (dst + term);
        left_next  = src_left ? blk_in.left : dst_next;
        right_next = src_left ? dst_next : blk_in.right;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= blk_in.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func_reg  <= blk_in.func;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign blk_out.valid = valid_reg;
    assign blk_out.func  = func_reg;
    assign blk_out.left  = left_reg;
    assign blk_out.right = right_reg;

endmodule
